// ===== hw/rtl/els_pkg.sv =====
// Shared types and constants for the ellipsoid line span unit.
package els_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int RATIO_BITS     = 17;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS_X = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS_Y = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS_Z = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_EXTENT_X = 3'd6;

   typedef struct packed {
      logic                  outside;
      logic [RATIO_BITS-1:0] ratio_y;
      logic [RATIO_BITS-1:0] ratio_z;
   } ratio_type;

   typedef struct packed {
      logic                  outside;
      logic [RATIO_BITS-1:0] root;
   } root_type;

endpackage

// ===== hw/rtl/ellipsoid_line_span_unit.sv =====
// Top level: registers, ratio and root pipelines, scaling and span clamp.
//
//  channel | ports                               | direction
//  req     | req_valid/ready, line_y, line_z      | in
//  rsp     | rsp_valid/ready, span_valid/start/end| out
//  csr     | csr_write_enable, csr_index, wdata   | in, write only
//
// One beat per cycle sustained while rsp_ready stays high.
// Each stage holds while its successor is full and stalled; bubbles close up.
// Synchronous reset empties the pipeline and loads register defaults.
module ellipsoid_line_span_unit
   import els_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [COORD_BITS-1:0]           req_line_y,
   input  logic [COORD_BITS-1:0]           req_line_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_span_valid,
   output logic [COORD_BITS-1:0]           rsp_span_start,
   output logic [COORD_BITS-1:0]           rsp_span_end,
   input  logic                            csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [COORD_BITS+FRAC_BITS-1:0] csr_wdata
);

   localparam int V  = COORD_BITS + FRAC_BITS;
   localparam int DF = FRAC_BITS + RATIO_BITS - 1;
   localparam int DW = V + RATIO_BITS;
   localparam int LW = V + RATIO_BITS + 2;
   localparam int EW = COORD_BITS + 2;
   localparam logic [V-1:0] ONE_FIX = V'(64'd1 << FRAC_BITS);
   localparam logic [COORD_BITS:0] EXT_MAX = (COORD_BITS+1)'(1) << COORD_BITS;
   localparam logic [LW-1:0] ALMOST_ONE = LW'((64'd99 << DF) / 64'd100);

   logic [V-1:0]        center_x_ff, center_y_ff, center_z_ff;
   logic [V-1:0]        radius_x_ff, radius_y_ff, radius_z_ff;
   logic [COORD_BITS:0] extent_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_x_ff <= ONE_FIX;
         radius_y_ff <= ONE_FIX;
         radius_z_ff <= ONE_FIX;
         extent_x_ff <= EXT_MAX;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CENTER_X: center_x_ff <= csr_wdata;
            REG_CENTER_Y: center_y_ff <= csr_wdata;
            REG_CENTER_Z: center_z_ff <= csr_wdata;
            REG_RADIUS_X: radius_x_ff <= csr_wdata;
            REG_RADIUS_Y: radius_y_ff <= csr_wdata;
            REG_RADIUS_Z: radius_z_ff <= csr_wdata;
            REG_EXTENT_X: extent_x_ff <= csr_wdata[COORD_BITS:0];
            default: ;
         endcase
      end
   end

   // zero Y or Z radius acts as one LSB
   logic [V-1:0] ry_eff, rz_eff;
   assign ry_eff = (radius_y_ff == '0) ? V'(1) : radius_y_ff;
   assign rz_eff = (radius_z_ff == '0) ? V'(1) : radius_z_ff;

   logic      ratio_valid, ratio_ready, root_valid, root_ready;
   ratio_type ratio_data;
   root_type  root_data;

   els_ratio_pipe #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_ratio (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .line_y   (req_line_y),
      .line_z   (req_line_z),
      .center_y (center_y_ff),
      .center_z (center_z_ff),
      .radius_y (ry_eff),
      .radius_z (rz_eff),
      .out_valid(ratio_valid),
      .out_ready(ratio_ready),
      .out_data (ratio_data)
   );

   els_root_pipe u_root (
      .clock    (clock),
      .reset    (reset),
      .in_valid (ratio_valid),
      .in_ready (ratio_ready),
      .in_data  (ratio_data),
      .out_valid(root_valid),
      .out_ready(root_ready),
      .out_data (root_data)
   );

   logic          m_vld_ff, a_vld_ff, b_vld_ff;
   logic          m_rdy, a_rdy, b_rdy;
   logic          m_out_ff, a_out_ff;
   logic [DW-1:0] d_ff;
   logic [EW-1:0] end_raw_ff, start_raw_ff;
   logic          lo_neg_ff;
   logic          span_valid_ff;
   logic [COORD_BITS-1:0] span_start_ff, span_end_ff;

   assign b_rdy      = !b_vld_ff || rsp_ready;
   assign a_rdy      = !a_vld_ff || b_rdy;
   assign m_rdy      = !m_vld_ff || a_rdy;
   assign root_ready = m_rdy;

   logic [LW-1:0] cxs, end_sum, lo;
   logic [COORD_BITS:0] ext_eff;
   logic [EW-1:0] end_clamp, start_v;
   logic          span_ok;

   always_comb begin
      cxs       = LW'({center_x_ff, {(RATIO_BITS-1){1'b0}}});
      end_sum   = cxs + LW'(d_ff);
      lo        = cxs - LW'(d_ff) + ALMOST_ONE;
      ext_eff   = (extent_x_ff > EXT_MAX) ? EXT_MAX : extent_x_ff;
      end_clamp = (end_raw_ff >= EW'(ext_eff)) ? EW'(ext_eff) - EW'(1) : end_raw_ff;
      start_v   = lo_neg_ff ? '0 : start_raw_ff;
      span_ok   = !a_out_ff && (ext_eff != '0) && (start_v <= end_clamp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (m_rdy) m_vld_ff <= root_valid;
         if (a_rdy) a_vld_ff <= m_vld_ff;
         if (b_rdy) b_vld_ff <= a_vld_ff;
      end
      if (m_rdy && root_valid) begin
         m_out_ff <= root_data.outside;
         d_ff     <= radius_x_ff * root_data.root;
      end
      if (a_rdy && m_vld_ff) begin
         a_out_ff     <= m_out_ff;
         end_raw_ff   <= end_sum[LW-2:DF];
         lo_neg_ff    <= lo[LW-1];
         start_raw_ff <= lo[LW-2:DF];
      end
      if (b_rdy && a_vld_ff) begin
         span_valid_ff <= span_ok;
         span_start_ff <= span_ok ? start_v[COORD_BITS-1:0] : '0;
         span_end_ff   <= span_ok ? end_clamp[COORD_BITS-1:0] : '0;
      end
   end

   assign rsp_valid      = b_vld_ff;
   assign rsp_span_valid = span_valid_ff;
   assign rsp_span_start = span_start_ff;
   assign rsp_span_end   = span_end_ff;

endmodule

// ===== hw/rtl/els_ratio_pipe.sv =====
// Per-axis distance and pipelined restoring divider, one quotient bit per stage.
module els_ratio_pipe
   import els_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [COORD_BITS-1:0]           line_y,
   input  logic [COORD_BITS-1:0]           line_z,
   input  logic [COORD_BITS+FRAC_BITS-1:0] center_y,
   input  logic [COORD_BITS+FRAC_BITS-1:0] center_z,
   input  logic [COORD_BITS+FRAC_BITS-1:0] radius_y,
   input  logic [COORD_BITS+FRAC_BITS-1:0] radius_z,
   output logic                            out_valid,
   input  logic                            out_ready,
   output ratio_type                       out_data
);

   localparam int V  = COORD_BITS + FRAC_BITS;
   localparam int NS = RATIO_BITS + 1;

   logic            vld_ff   [NS];
   logic            outs_ff  [NS];
   logic [V:0]      rem_y_ff [NS];
   logic [V:0]      rem_z_ff [NS];
   logic [RATIO_BITS-1:0] quo_y_ff [NS];
   logic [RATIO_BITS-1:0] quo_z_ff [NS];
   logic            rdy      [NS+1];

   logic [V-1:0] pos_y, pos_z;
   logic [V-1:0] dist_y_in, dist_z_in;

   assign rdy[NS] = out_ready;

   genvar gi;
   generate
      for (gi = 0; gi < NS; gi++) begin : g_rdy
         assign rdy[gi] = !vld_ff[gi] || rdy[gi+1];
      end
   endgenerate

   assign in_ready = rdy[0];

   always_comb begin
      pos_y     = {line_y, {FRAC_BITS{1'b0}}};
      pos_z     = {line_z, {FRAC_BITS{1'b0}}};
      dist_y_in = (center_y >= pos_y) ? center_y - pos_y : pos_y - center_y;
      dist_z_in = (center_z >= pos_z) ? center_z - pos_z : pos_z - center_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (rdy[0]) begin
         vld_ff[0] <= in_valid;
      end
      if (rdy[0] && in_valid) begin
         outs_ff[0]  <= 1'b0;
         rem_y_ff[0] <= {1'b0, dist_y_in};
         rem_z_ff[0] <= {1'b0, dist_z_in};
         quo_y_ff[0] <= '0;
         quo_z_ff[0] <= '0;
      end
   end

   generate
      for (gi = 1; gi < NS; gi++) begin : g_step
         logic [V+1:0] cmp_y, cmp_z;
         logic         bit_y, bit_z;
         logic         big_in;
         logic [V:0]   rem_y_in, rem_z_in;

         always_comb begin
            if (gi == 1) begin
               cmp_y  = {1'b0, rem_y_ff[gi-1]};
               cmp_z  = {1'b0, rem_z_ff[gi-1]};
               big_in = ({1'b0, rem_y_ff[gi-1]} >= {1'b0, radius_y, 1'b0})
                     || ({1'b0, rem_z_ff[gi-1]} >= {1'b0, radius_z, 1'b0});
            end else begin
               cmp_y  = {rem_y_ff[gi-1], 1'b0};
               cmp_z  = {rem_z_ff[gi-1], 1'b0};
               big_in = 1'b0;
            end
            bit_y    = cmp_y >= {2'b00, radius_y};
            bit_z    = cmp_z >= {2'b00, radius_z};
            rem_y_in = bit_y ? (V+1)'(cmp_y - {2'b00, radius_y}) : (V+1)'(cmp_y);
            rem_z_in = bit_z ? (V+1)'(cmp_z - {2'b00, radius_z}) : (V+1)'(cmp_z);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[gi] <= 1'b0;
            end else if (rdy[gi]) begin
               vld_ff[gi] <= vld_ff[gi-1];
            end
            if (rdy[gi] && vld_ff[gi-1]) begin
               outs_ff[gi]  <= outs_ff[gi-1] || big_in;
               rem_y_ff[gi] <= rem_y_in;
               rem_z_ff[gi] <= rem_z_in;
               quo_y_ff[gi] <= {quo_y_ff[gi-1][RATIO_BITS-2:0], bit_y};
               quo_z_ff[gi] <= {quo_z_ff[gi-1][RATIO_BITS-2:0], bit_z};
            end
         end
      end
   endgenerate

   assign out_valid        = vld_ff[NS-1];
   assign out_data.outside = outs_ff[NS-1];
   assign out_data.ratio_y = quo_y_ff[NS-1];
   assign out_data.ratio_z = quo_z_ff[NS-1];

endmodule

// ===== hw/rtl/els_root_pipe.sv =====
// Squares, sum and pipelined bitwise square root, one root bit per stage.
module els_root_pipe
   import els_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  ratio_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output root_type  out_data
);

   localparam int NS = RATIO_BITS + 2;
   localparam int SQ = 2 * RATIO_BITS;
   localparam int RW = 2 * RATIO_BITS - 1;
   localparam logic [RATIO_BITS-1:0] ONE_RATIO = RATIO_BITS'(1) << (RATIO_BITS - 1);
   localparam logic [SQ:0] ONE_SQ = (SQ+1)'(1) << (2 * (RATIO_BITS - 1));

   logic                  vld_ff  [NS];
   logic                  outs_ff [NS];
   logic [SQ-1:0]         sq_y_ff;
   logic [SQ-1:0]         sq_z_ff;
   logic [RW-1:0]         rem_ff  [NS];
   logic [RATIO_BITS-1:0] res_ff  [NS];
   logic                  rdy     [NS+1];

   logic [SQ:0] sum_q;

   assign rdy[NS] = out_ready;

   genvar gi;
   generate
      for (gi = 0; gi < NS; gi++) begin : g_rdy
         assign rdy[gi] = !vld_ff[gi] || rdy[gi+1];
      end
   endgenerate

   assign in_ready = rdy[0];
   assign sum_q    = {1'b0, sq_y_ff} + {1'b0, sq_z_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         if (rdy[1]) vld_ff[1] <= vld_ff[0];
      end
      if (rdy[0] && in_valid) begin
         outs_ff[0] <= in_data.outside || (in_data.ratio_y > ONE_RATIO)
                    || (in_data.ratio_z > ONE_RATIO);
         sq_y_ff    <= in_data.ratio_y * in_data.ratio_y;
         sq_z_ff    <= in_data.ratio_z * in_data.ratio_z;
      end
      if (rdy[1] && vld_ff[0]) begin
         outs_ff[1] <= outs_ff[0] || (sum_q > ONE_SQ);
         rem_ff[1]  <= RW'(ONE_SQ - sum_q);
         res_ff[1]  <= '0;
      end
   end

   generate
      for (gi = 2; gi < NS; gi++) begin : g_step
         localparam int B = NS - 1 - gi;
         logic [RW+1:0] trial;
         logic          take;

         always_comb begin
            trial = ((RW+2)'(res_ff[gi-1]) << (B + 1)) + ((RW+2)'(1) << (2 * B));
            take  = {2'b00, rem_ff[gi-1]} >= trial;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[gi] <= 1'b0;
            end else if (rdy[gi]) begin
               vld_ff[gi] <= vld_ff[gi-1];
            end
            if (rdy[gi] && vld_ff[gi-1]) begin
               outs_ff[gi] <= outs_ff[gi-1];
               rem_ff[gi]  <= take ? RW'({2'b00, rem_ff[gi-1]} - trial) : rem_ff[gi-1];
               res_ff[gi]  <= take ? (res_ff[gi-1] | (RATIO_BITS'(1) << B)) : res_ff[gi-1];
            end
         end
      end
   endgenerate

   assign out_valid        = vld_ff[NS-1];
   assign out_data.outside = outs_ff[NS-1];
   assign out_data.root    = res_ff[NS-1];

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the ellipsoid line span unit: directed table, random lines, predictor check.
`timescale 1ns / 100ps
module tb_top;
   import els_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int VB = CB + FB;
   localparam int DF = FB + 16;
   localparam logic [63:0] ALMOST_ONE = (64'd99 << DF) / 64'd100;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic          ok;
      logic [CB-1:0] first;
      logic [CB-1:0] last;
   } span_type;

   typedef struct {
      logic [CB-1:0] y;
      logic [CB-1:0] z;
      logic          known;
      span_type      span;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [CB-1:0] req_line_y = '0;
   logic [CB-1:0] req_line_z = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_span_valid;
   logic [CB-1:0] rsp_span_start;
   logic [CB-1:0] rsp_span_end;
   logic csr_write_enable = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [VB-1:0] csr_wdata = '0;

   ellipsoid_line_span_unit i_dut (.*);

   logic [VB-1:0] cen_x, cen_y, cen_z, rad_x, rad_y, rad_z;
   logic [CB:0] ext_x;
   span_type spans_due[$];
   int errors = 0;
   int send_idle = 0;
   int recv_stall = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [63:0] ratio_of(logic [VB-1:0] c, logic [CB-1:0] p,
                                            logic [VB-1:0] r);
      logic [63:0] pos;
      logic [63:0] gap;
      pos = 64'(p) << FB;
      gap = (64'(c) >= pos) ? 64'(c) - pos : pos - 64'(c);
      return (gap << 16) / ((r == 0) ? 64'd1 : 64'(r));
   endfunction

   function automatic span_type span_of(logic [CB-1:0] y, logic [CB-1:0] z);
      logic [63:0] ay, az, q, s, rt, t, d, cxs, ext, hi;
      longint lo;
      span_type res;
      res = '0;
      ay = ratio_of(cen_y, y, rad_y);
      az = ratio_of(cen_z, z, rad_z);
      if (ay > 64'h10000 || az > 64'h10000) return res;
      q = ay * ay + az * az;
      if (q > 64'h1_0000_0000) return res;
      s = 64'h1_0000_0000 - q;
      rt = 0;
      for (int b = 16; b >= 0; b--) begin
         t = rt | (64'd1 << b);
         if (t * t <= s) rt = t;
      end
      d = 64'(rad_x) * rt;
      cxs = 64'(cen_x) << 16;
      ext = (ext_x > (1 << CB)) ? (64'd1 << CB) : 64'(ext_x);
      if (ext == 0) return res;
      hi = (cxs + d) >> DF;
      if (hi >= ext) hi = ext - 1;
      lo = longint'(cxs) - longint'(d) + longint'(ALMOST_ONE);
      t = (lo < 0) ? 64'd0 : (64'(lo) >> DF);
      if (t > hi) return res;
      res.ok = 1;
      res.first = t[CB-1:0];
      res.last = hi[CB-1:0];
      return res;
   endfunction

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [VB-1:0] val);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         REG_CENTER_X: cen_x = val;
         REG_CENTER_Y: cen_y = val;
         REG_CENTER_Z: cen_z = val;
         REG_RADIUS_X: rad_x = val;
         REG_RADIUS_Y: rad_y = val;
         REG_RADIUS_Z: rad_z = val;
         REG_EXTENT_X: ext_x = val[CB:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_shape(logic [VB-1:0] cx, logic [VB-1:0] cy, logic [VB-1:0] cz,
                            logic [VB-1:0] rx, logic [VB-1:0] ry, logic [VB-1:0] rz,
                            logic [VB-1:0] ex);
      write_reg(REG_CENTER_X, cx);
      write_reg(REG_CENTER_Y, cy);
      write_reg(REG_CENTER_Z, cz);
      write_reg(REG_RADIUS_X, rx);
      write_reg(REG_RADIUS_Y, ry);
      write_reg(REG_RADIUS_Z, rz);
      write_reg(REG_EXTENT_X, ex);
   endtask

   task automatic send_line(logic [CB-1:0] y, logic [CB-1:0] z, logic known,
                            span_type want);
      span_type calc;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_line_y <= y;
      req_line_z <= z;
      calc = span_of(y, z);
      if (known && calc !== want)
         $display("%0t note: table row %h/%h differs from predictor", $time, y, z);
      spans_due.push_back(known ? want : calc);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      int n;
      n = 0;
      req_valid <= 0;
      while (spans_due.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (60) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (spans_due.size() == 0) begin
               $display("%0t unexpected beat: actual %b %h %h", $time,
                        rsp_span_valid, rsp_span_start, rsp_span_end);
               errors++;
            end else begin
               span_type w;
               w = spans_due.pop_front();
               if (rsp_span_valid !== w.ok || rsp_span_start !== w.first ||
                   rsp_span_end !== w.last) begin
                  $display("%0t mismatch: expected %b %h %h actual %b %h %h", $time,
                           w.ok, w.first, w.last, rsp_span_valid, rsp_span_start,
                           rsp_span_end);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   row_type rows[$];

   function automatic span_type sp(logic ok, int a, int b);
      span_type r;
      r.ok = ok;
      r.first = a[CB-1:0];
      r.last = b[CB-1:0];
      return r;
   endfunction

   function automatic logic [VB-1:0] rnd_val(logic [VB-1:0] lim);
      return VB'($urandom_range(int'(lim)));
   endfunction

   initial begin
      logic [CB-1:0] y, z;
      int cy, cz;
      cen_x = 0; cen_y = 0; cen_z = 0;
      rad_x = 1 << FB; rad_y = 1 << FB; rad_z = 1 << FB;
      ext_x = 1 << CB;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset shape: unit sphere at origin
      rows.push_back('{0, 0, 1, sp(1, 0, 1)});
      rows.push_back('{1, 0, 1, sp(1, 0, 0)});
      rows.push_back('{0, 1, 1, sp(1, 0, 0)});
      rows.push_back('{2, 0, 1, sp(0, 0, 0)});
      rows.push_back('{4095, 4095, 1, sp(0, 0, 0)});
      rows.push_back('{1, 1, 1, sp(0, 0, 0)});
      foreach (rows[i]) send_line(rows[i].y, rows[i].z, rows[i].known, rows[i].span);
      drain();

      // big sphere, clamped both ends
      set_shape(20'd2048 << FB, 20'd100 << FB, 0, 20'd3000 << FB, 20'd50 << FB,
                20'd50 << FB, 13'd4096);
      send_line(100, 0, 1, sp(1, 0, 4095));
      send_line(0, 0, 0, '0);
      send_line(150, 0, 0, '0);
      send_line(151, 0, 1, sp(0, 0, 0));
      send_line(4095, 0, 0, '0);
      drain();
      // zero radii, zero extent
      set_shape(20'hFFFFF, 0, 0, 0, 0, 0, 0);
      send_line(0, 0, 1, sp(0, 0, 0));
      send_line(4095, 4095, 0, '0);
      drain();
      // large extent, max registers
      set_shape(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                13'h1FFF);
      send_line(4095, 4095, 0, '0);
      send_line(0, 0, 0, '0);
      send_line(2048, 2048, 0, '0);
      send_line(12'hAAA, 12'h555, 0, '0);
      drain();
      write_reg(REG_UNUSED, 20'h12345);
      send_line(4095, 0, 0, '0);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 58; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 58; end
            default: begin send_idle = 32; recv_stall = 32; end
         endcase
         if (ph == 9)
            set_shape(rnd_val(20'hFFFFF), rnd_val(20'hFFFFF), rnd_val(20'hFFFFF),
                      rnd_val(20'hFFFFF), rnd_val(20'hFFFFF), rnd_val(20'hFFFFF),
                      VB'($urandom_range(8191)));
         else
            set_shape(rnd_val(20'hFFFFF), rnd_val(20'hFFFFF), rnd_val(20'hFFFFF),
                      VB'($urandom_range(1, 20'h40000)), VB'($urandom_range(1, 20'h8000)),
                      VB'($urandom_range(1, 20'h8000)), VB'($urandom_range(1, 4200)));
         cy = int'(cen_y >> FB);
         cz = int'(cen_z >> FB);
         for (int k = 0; k < 50; k++) begin
            if ($urandom_range(9) < 2) begin
               y = CB'($urandom);
               z = CB'($urandom);
            end else begin
               y = CB'(cy + $urandom_range(0, int'(rad_y >> FB) * 2 + 2)
                       - int'(rad_y >> FB) - 1);
               z = CB'(cz + $urandom_range(0, int'(rad_z >> FB) * 2 + 2)
                       - int'(rad_z >> FB) - 1);
            end
            send_line(y, z, 0, '0);
            if (k == 25 && ph == 1) drain();
         end
         drain();
      end

      if (spans_due.size() != 0) begin
         $display("%0t %0d spans never arrived", $time, spans_due.size());
         errors++;
      end
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/els_pkg.sv
hw/rtl/els_ratio_pipe.sv
hw/rtl/els_root_pipe.sv
hw/rtl/ellipsoid_line_span_unit.sv
tb/tb_top.sv
